/* hdl/lctr_pkg.sv */
package lctr_pkg;

   localparam int BLOCK_SAMPLES = 5000;
   localparam int CAPACITY      = 262144;

   localparam logic [31:0] RUN_LIMIT = 32'hFFFF_FF00;
   localparam logic [7:0]  MASK_ALL  = 8'hFF;

   localparam int OPCODE_W = 2;
   localparam int SAMPLE_W = 8;
   localparam int LENGTH_W = 32;
   localparam int SKIP_W   = 16;
   localparam int BLOCKS_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int REC_W = $clog2(CAPACITY);
   localparam int BSC_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

   localparam logic [REC_W-1:0] REC_LAST_CLOSE = REC_W'(CAPACITY - 2);
   localparam logic [BSC_W-1:0] BSC_LAST       = BSC_W'(BLOCK_SAMPLES - 1);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STOP   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_VALUE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_MASK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 3'd4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_FIRST,
      PH_CAPT
   } phase_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic [LENGTH_W-1:0] length;
      logic                last;
   } rec_type;

   // one queue entry: one or two records caused by a single sample
   typedef struct packed {
      logic                two;
      rec_type             rec0;
      logic [SAMPLE_W-1:0] value1;
      logic [LENGTH_W-1:0] length1;
   } evt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

/* hdl/lctr_if.sv */
interface lctr_req_if import lctr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface lctr_rsp_if import lctr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] run_value;
   logic [LENGTH_W-1:0] run_length;
   logic                last;

   modport source (output valid, output run_value, output run_length, output last,
                   input ready);
   modport sink   (input valid, input run_value, input run_length, input last,
                   output ready);
endinterface

/* hdl/lctr_front.sv */
module lctr_front import lctr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lctr_req_if.sink              req_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  fifo_stat_type         stat,
   output logic                  push,
   output evt_type               push_data
);

   logic                trig_enable_ff;
   logic [SAMPLE_W-1:0] trig_value_ff;
   logic [SAMPLE_W-1:0] trig_mask_ff;
   logic [SKIP_W-1:0]   skip_count_ff;
   logic [BLOCKS_W-1:0] block_count_ff;

   phase_type           phase_ff, phase_in;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic [LENGTH_W-1:0] run_ff, run_in;
   logic [REC_W-1:0]    rec_ff, rec_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic [BSC_W-1:0]    bsc_ff, bsc_in;
   logic [BLOCKS_W-1:0] blocks_ff, blocks_in;
   logic                stop_ff, stop_in;

   logic accept;
   logic trig_wait;
   logic trig_hit;

   assign req_chan.ready = !stat.full;
   assign accept    = req_chan.valid && req_chan.ready;
   assign trig_wait = trig_enable_ff && (trig_mask_ff != '0) && (trig_mask_ff != MASK_ALL);
   assign trig_hit  = (req_chan.sample & trig_mask_ff) == (trig_value_ff & trig_mask_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_enable_ff <= 1'b0;
         trig_value_ff  <= '0;
         trig_mask_ff   <= '0;
         skip_count_ff  <= '0;
         block_count_ff <= BLOCKS_W'(2);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIG_ENABLE: trig_enable_ff <= csr_wdata[0];
            CSR_TRIG_VALUE:  trig_value_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_TRIG_MASK:   trig_mask_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_SKIP_COUNT:  skip_count_ff  <= csr_wdata[SKIP_W-1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[BLOCKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         held_ff   <= '0;
         run_ff    <= '0;
         rec_ff    <= '0;
         skip_ff   <= '0;
         bsc_ff    <= '0;
         blocks_ff <= '0;
         stop_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         run_ff    <= run_in;
         rec_ff    <= rec_in;
         skip_ff   <= skip_in;
         bsc_ff    <= bsc_in;
         blocks_ff <= blocks_in;
         stop_ff   <= stop_in;
      end
   end

   always_comb begin
      logic closed;
      logic done;
      phase_in  = phase_ff;
      held_in   = held_ff;
      run_in    = run_ff;
      rec_in    = rec_ff;
      skip_in   = skip_ff;
      bsc_in    = bsc_ff;
      blocks_in = blocks_ff;
      stop_in   = stop_ff;
      push      = 1'b0;
      push_data = '0;
      closed    = 1'b0;
      done      = 1'b0;

      if (accept) begin
         case (req_chan.opcode)
            OP_START: begin
               run_in    = '0;
               rec_in    = '0;
               skip_in   = '0;
               bsc_in    = '0;
               blocks_in = '0;
               stop_in   = 1'b0;
               phase_in  = trig_wait ? PH_TRIG : PH_FIRST;
            end
            OP_STOP: begin
               if (phase_ff == PH_TRIG) begin
                  stop_in  = 1'b1;
                  phase_in = PH_FIRST;
               end else if (phase_ff != PH_IDLE) begin
                  stop_in = 1'b1;
               end
            end
            OP_SAMPLE: begin
               unique case (phase_ff)
                  PH_IDLE: ;
                  PH_TRIG: begin
                     if (trig_hit) phase_in = PH_FIRST;
                  end
                  PH_FIRST: begin
                     held_in   = req_chan.sample;
                     run_in    = LENGTH_W'(1);
                     skip_in   = '0;
                     bsc_in    = '0;
                     blocks_in = (block_count_ff == '0) ? BLOCKS_W'(1) : block_count_ff;
                     phase_in  = PH_CAPT;
                  end
                  PH_CAPT: begin
                     if (skip_ff < skip_count_ff) begin
                        skip_in = skip_ff + SKIP_W'(1);
                     end else begin
                        skip_in = '0;
                        if (req_chan.sample == held_ff && run_ff < RUN_LIMIT) begin
                           run_in = run_ff + LENGTH_W'(1);
                        end else begin
                           // close the current run
                           closed                = 1'b1;
                           push                  = 1'b1;
                           push_data.rec0.value  = held_ff;
                           push_data.rec0.length = run_ff;
                           push_data.rec0.last   = 1'b0;
                           rec_in                = rec_ff + REC_W'(1);
                           held_in               = req_chan.sample;
                           run_in                = LENGTH_W'(1);
                           if (rec_ff == REC_LAST_CLOSE) begin
                              // buffer full: emit the new run as final
                              done              = 1'b1;
                              push_data.two     = 1'b1;
                              push_data.value1  = req_chan.sample;
                              push_data.length1 = LENGTH_W'(1);
                           end
                        end
                        if (!done) begin
                           if (bsc_ff == BSC_LAST) begin
                              bsc_in = '0;
                              if (blocks_ff <= BLOCKS_W'(1) || stop_ff) begin
                                 blocks_in = '0;
                                 done      = 1'b1;
                                 push      = 1'b1;
                                 if (closed) begin
                                    push_data.two     = 1'b1;
                                    push_data.value1  = held_in;
                                    push_data.length1 = run_in;
                                 end else begin
                                    push_data.rec0.value  = held_in;
                                    push_data.rec0.length = run_in;
                                    push_data.rec0.last   = 1'b1;
                                 end
                              end else begin
                                 blocks_in = blocks_ff - BLOCKS_W'(1);
                              end
                           end else begin
                              bsc_in = bsc_ff + BSC_W'(1);
                           end
                        end
                        if (done) begin
                           phase_in = PH_IDLE;
                           stop_in  = 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

endmodule

/* hdl/lctr_fifo.sv */
module lctr_fifo import lctr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  evt_type       push_data,
   input  logic          pop,
   output evt_type       head,
   output fifo_stat_type stat
);

   evt_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;

   function automatic logic [FIFO_PTR_W-1:0] next_ptr(input logic [FIFO_PTR_W-1:0] p);
      return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
   endfunction

   assign stat.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + FIFO_CNT_W'(1);
      else if (pop && !push) count_in = count_ff - FIFO_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && stat.full |-> pop)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("queue underflow");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + FIFO_CNT_W'(1))
      else $error("queue count lost a push");
`endif

endmodule

/* hdl/lctr_back.sv */
module lctr_back import lctr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  evt_type       head,
   input  fifo_stat_type stat,
   output logic          pop,
   lctr_rsp_if.source    rsp_chan
);

   logic                valid_ff, valid_in;
   logic                sel_ff, sel_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic                last_ff, last_in;
   logic                load;

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.run_value  = value_ff;
   assign rsp_chan.run_length = length_ff;
   assign rsp_chan.last       = last_ff;

   assign load = (!valid_ff || rsp_chan.ready) && !stat.empty;
   // hold the entry until its second record has gone out
   assign pop  = load && (!head.two || sel_ff);

   always_comb begin
      valid_in  = valid_ff;
      sel_in    = sel_ff;
      value_in  = value_ff;
      length_in = length_ff;
      last_in   = last_ff;
      if (valid_ff && rsp_chan.ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (sel_ff) begin
            value_in  = head.value1;
            length_in = head.length1;
            last_in   = 1'b1;
            sel_in    = 1'b0;
         end else begin
            value_in  = head.rec0.value;
            length_in = head.rec0.length;
            last_in   = head.rec0.last;
            sel_in    = head.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      length_ff <= length_in;
      last_ff   <= last_in;
   end

`ifndef ASSERT_OFF
   a_sel_has_second: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> !stat.empty && head.two)
      else $error("second record selected without a two-record entry");
   a_second_is_last: assert property (@(posedge clock) disable iff (reset)
      load && sel_ff |=> valid_ff && last_ff)
      else $error("second record of an entry not marked final");
`endif

endmodule

/* hdl/logic_capture_trigger_rle.sv */
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+---------------------------------
// req_chan  | in  | valid/ready          | opcode[1:0], sample[7:0]
// rsp_chan  | out | valid/ready          | run_value[7:0], run_length[31:0], last
// csr_*     | in  | csr_we (no wait)     | csr_index[2:0], csr_wdata[15:0]
//
// One request is taken per cycle while the queue has room; the front end updates
// all capture state in the cycle of the transfer and queues records in a 4-entry
// queue. Records leave through a registered output, one per cycle while rsp_chan
// is ready; a sample that closes a run and ends the capture yields two records.
// req_chan.ready drops only while the queue is full, i.e. when rsp_chan stalls.
// Reset is synchronous and clears control state; registers return to defaults.
module logic_capture_trigger_rle import lctr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lctr_req_if.sink              req_chan,
   lctr_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   fifo_stat_type stat;
   logic          push;
   logic          pop;
   evt_type       push_data;
   evt_type       head;

   lctr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .push      (push),
      .push_data (push_data)
   );

   lctr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   lctr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .stat     (stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
